// ===== src/coo_pkg.sv =====
// Package with shared types and fixed field widths for the COO to CSR converter.
package coo_pkg;

    // Fixed widths of the stream fields.
    localparam int CMD_W = 3;
    localparam int ROW_W = 13;
    localparam int VAL_W = 64;
    localparam int POS_W = 17;
    localparam int STS_W = 2;
    localparam int CFG_W = 13;

    // Width of the stored offsets and slots; sums wrap at this width.
    localparam int ACC_W = 32;

    // Reset value of the rows_in_use register.
    localparam logic [CFG_W-1:0] ROWS_RESET = 13'd4096;

    // Command codes carried in the input tuser.
    typedef enum logic [CMD_W-1:0] {
        CMD_COUNT = 3'd0,
        CMD_BUILD = 3'd1,
        CMD_PLACE = 3'd2,
        CMD_READ  = 3'd3,
        CMD_CLEAR = 3'd4
    } t_cmd;

    // Status codes carried in the output tuser.
    typedef enum logic [STS_W-1:0] {
        STS_OK   = 2'd0,
        STS_ROW  = 2'd1,
        STS_FULL = 2'd2
    } t_sts;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_CLR,
        S_DISP,
        S_EXEC,
        S_BLD_RD,
        S_BLD_WR,
        S_REPLY
    } t_state;

endpackage

// ===== src/coo_ram.sv =====
// Simple dual-port RAM with one write port and one registered read port.
module coo_ram #(
    parameter int DEPTH = 4097,
    parameter int WIDTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/coo_alu.sv =====
// Shared adder and capacity compare used by count, build and place.
module coo_alu #(
    parameter int LIMIT = 65536
) (
    input  logic [coo_pkg::ACC_W-1:0] i_a,
    input  logic [coo_pkg::ACC_W-1:0] i_b,
    output logic [coo_pkg::ACC_W-1:0] o_sum,
    output logic                      o_ge
);

    // Wrapping sum and the check of operand a against the capacity.
    assign o_sum = i_a + i_b;
    assign o_ge  = (i_a >= coo_pkg::ACC_W'(LIMIT));

endmodule

// ===== src/coo_ctrl.sv =====
// Sequencer that runs each command through the offset and slot memories.
module coo_ctrl #(
    parameter int ROWS_MAX    = 4096,
    parameter int ENTRIES_MAX = 65536,
    parameter int COL_BITS    = 20,
    localparam int AW  = $clog2(ROWS_MAX + 1),
    localparam int NAW = $clog2(ROWS_MAX)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [coo_pkg::CFG_W-1:0]    i_rows_in_use,
    // Input item
    input  logic                         i_valid,
    output logic                         o_ready,
    input  coo_pkg::t_cmd                i_cmd,
    input  logic [coo_pkg::ROW_W-1:0]    i_row,
    input  logic [COL_BITS-1:0]          i_col,
    input  logic [coo_pkg::VAL_W-1:0]    i_val,
    // Result item
    output logic                         o_res_valid,
    input  logic                         i_res_ready,
    output logic [coo_pkg::POS_W-1:0]    o_pos,
    output logic [COL_BITS-1:0]          o_col,
    output logic [coo_pkg::VAL_W-1:0]    o_val,
    output coo_pkg::t_sts                o_sts,
    // Row offset memory
    output logic                         o_ro_we,
    output logic [AW-1:0]                o_ro_waddr,
    output logic [coo_pkg::ACC_W-1:0]    o_ro_wdata,
    output logic [AW-1:0]                o_ro_raddr,
    input  logic [coo_pkg::ACC_W-1:0]    i_ro_rdata,
    // Next free slot memory
    output logic                         o_nfs_we,
    output logic [NAW-1:0]               o_nfs_waddr,
    output logic [coo_pkg::ACC_W-1:0]    o_nfs_wdata,
    output logic [NAW-1:0]               o_nfs_raddr,
    input  logic [coo_pkg::ACC_W-1:0]    i_nfs_rdata,
    // Shared adder
    output logic [coo_pkg::ACC_W-1:0]    o_alu_a,
    output logic [coo_pkg::ACC_W-1:0]    o_alu_b,
    input  logic [coo_pkg::ACC_W-1:0]    i_alu_sum,
    input  logic                         i_alu_ge
);

    localparam int CW = (AW > coo_pkg::ROW_W) ? AW : coo_pkg::ROW_W;
    localparam int TW = $clog2(ENTRIES_MAX + 1);

    // Control state.
    coo_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_idx, n_idx;
    logic [TW-1:0]   r_total, n_total;
    logic            r_clr_reply, n_clr_reply;

    // Item and result payload.
    coo_pkg::t_cmd               r_cmd, n_cmd;
    logic [coo_pkg::ROW_W-1:0]   r_row, n_row;
    logic [COL_BITS-1:0]         r_col, n_col;
    logic [coo_pkg::VAL_W-1:0]   r_val, n_val;
    logic [coo_pkg::ACC_W-1:0]   r_acc, n_acc;
    logic [coo_pkg::POS_W-1:0]   r_pos, n_pos;
    logic [COL_BITS-1:0]         r_col_res, n_col_res;
    logic [coo_pkg::VAL_W-1:0]   r_val_res, n_val_res;
    coo_pkg::t_sts               r_sts, n_sts;

    // Effective row count and row arithmetic in a common width.
    logic [CW-1:0]             w_cfg_ext;
    logic [CW-1:0]             w_n;
    logic [CW-1:0]             w_row_ext;
    logic [CW-1:0]             w_row_p1;
    logic [CW-1:0]             w_idx_ext;
    logic [AW-1:0]             w_idx_p1;
    logic [TW-1:0]             w_total_inc;
    logic [coo_pkg::ACC_W-1:0] w_total32;
    logic [coo_pkg::ACC_W-1:0] w_total_inc32;

    assign w_cfg_ext     = CW'(i_rows_in_use);
    assign w_n           = (w_cfg_ext == '0) ? CW'(1) :
                           (w_cfg_ext > CW'(ROWS_MAX)) ? CW'(ROWS_MAX) : w_cfg_ext;
    assign w_row_ext     = CW'(r_row);
    assign w_row_p1      = w_row_ext + CW'(1);
    assign w_idx_ext     = CW'(r_idx);
    assign w_idx_p1      = r_idx + AW'(1);
    assign w_total_inc   = r_total + TW'(1);
    assign w_total32     = coo_pkg::ACC_W'(r_total);
    assign w_total_inc32 = coo_pkg::ACC_W'(w_total_inc);

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= coo_pkg::S_CLR;
            r_idx       <= '0;
            r_total     <= '0;
            r_clr_reply <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_total     <= n_total;
            r_clr_reply <= n_clr_reply;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_row     <= n_row;
        r_col     <= n_col;
        r_val     <= n_val;
        r_acc     <= n_acc;
        r_pos     <= n_pos;
        r_col_res <= n_col_res;
        r_val_res <= n_val_res;
        r_sts     <= n_sts;
    end

    // Next state, memory accesses and adder operands.
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_total     = r_total;
        n_clr_reply = r_clr_reply;
        n_cmd       = r_cmd;
        n_row       = r_row;
        n_col       = r_col;
        n_val       = r_val;
        n_acc       = r_acc;
        n_pos       = r_pos;
        n_col_res   = r_col_res;
        n_val_res   = r_val_res;
        n_sts       = r_sts;

        o_ready     = 1'b0;
        o_res_valid = 1'b0;
        o_ro_we     = 1'b0;
        o_ro_waddr  = r_idx;
        o_ro_wdata  = '0;
        o_ro_raddr  = w_row_ext[AW-1:0];
        o_nfs_we    = 1'b0;
        o_nfs_waddr = w_row_ext[NAW-1:0];
        o_nfs_wdata = i_alu_sum;
        o_nfs_raddr = w_row_ext[NAW-1:0];
        o_alu_a     = i_ro_rdata;
        o_alu_b     = coo_pkg::ACC_W'(1);

        unique case (r_state)
            coo_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_cmd     = i_cmd;
                    n_row     = i_row;
                    n_col     = i_col;
                    n_val     = i_val;
                    n_pos     = '0;
                    n_col_res = '0;
                    n_val_res = '0;
                    n_sts     = coo_pkg::STS_OK;
                    n_state   = coo_pkg::S_DISP;
                end
            end

            // Range and capacity checks, then the first memory read.
            coo_pkg::S_DISP: begin
                n_state = coo_pkg::S_REPLY;
                unique case (r_cmd)
                    coo_pkg::CMD_COUNT: begin
                        n_pos = w_total32[coo_pkg::POS_W-1:0];
                        if (w_row_ext >= w_n) begin
                            n_sts = coo_pkg::STS_ROW;
                        end else if (r_total >= TW'(ENTRIES_MAX)) begin
                            n_sts = coo_pkg::STS_FULL;
                        end else begin
                            o_ro_raddr = w_row_p1[AW-1:0];
                            n_state    = coo_pkg::S_EXEC;
                        end
                    end
                    coo_pkg::CMD_BUILD: begin
                        // Offset of row zero is always zero.
                        n_idx   = '0;
                        n_acc   = '0;
                        n_state = coo_pkg::S_BLD_RD;
                    end
                    coo_pkg::CMD_PLACE: begin
                        if (w_row_ext >= w_n) begin
                            n_sts = coo_pkg::STS_ROW;
                        end else begin
                            o_nfs_raddr = w_row_ext[NAW-1:0];
                            n_state     = coo_pkg::S_EXEC;
                        end
                    end
                    coo_pkg::CMD_READ: begin
                        if (w_row_ext > w_n) begin
                            n_sts = coo_pkg::STS_ROW;
                        end else begin
                            o_ro_raddr = w_row_ext[AW-1:0];
                            n_state    = coo_pkg::S_EXEC;
                        end
                    end
                    coo_pkg::CMD_CLEAR: begin
                        n_idx       = '0;
                        n_clr_reply = 1'b1;
                        n_state     = coo_pkg::S_CLR;
                    end
                    default: begin
                        n_state = coo_pkg::S_REPLY;
                    end
                endcase
            end

            // Read data is back: count and place update their memory through the shared adder; read keeps it.
            coo_pkg::S_EXEC: begin
                n_state = coo_pkg::S_REPLY;
                case (r_cmd)
                    coo_pkg::CMD_COUNT: begin
                        o_ro_we    = 1'b1;
                        o_ro_waddr = w_row_p1[AW-1:0];
                        o_ro_wdata = i_alu_sum;
                        n_total    = w_total_inc;
                        n_pos      = w_total_inc32[coo_pkg::POS_W-1:0];
                    end
                    coo_pkg::CMD_PLACE: begin
                        o_alu_a = i_nfs_rdata;
                        if (i_alu_ge) begin
                            n_sts = coo_pkg::STS_FULL;
                        end else begin
                            o_nfs_we    = 1'b1;
                            o_nfs_waddr = w_row_ext[NAW-1:0];
                            o_nfs_wdata = i_alu_sum;
                            n_pos       = i_nfs_rdata[coo_pkg::POS_W-1:0];
                            n_col_res   = r_col;
                            n_val_res   = r_val;
                        end
                    end
                    coo_pkg::CMD_READ: begin
                        n_pos = i_ro_rdata[coo_pkg::POS_W-1:0];
                    end
                    default: begin
                        n_state = coo_pkg::S_REPLY;
                    end
                endcase
            end

            // Build: fetch the count of row idx.
            coo_pkg::S_BLD_RD: begin
                o_ro_raddr = w_idx_p1;
                n_state    = coo_pkg::S_BLD_WR;
            end

            // Build: add the running offset and record the next free slot.
            coo_pkg::S_BLD_WR: begin
                o_alu_b     = r_acc;
                o_ro_we     = 1'b1;
                o_ro_waddr  = w_idx_p1;
                o_ro_wdata  = i_alu_sum;
                o_nfs_we    = 1'b1;
                o_nfs_waddr = r_idx[NAW-1:0];
                o_nfs_wdata = r_acc;
                n_acc       = i_alu_sum;
                if (w_idx_ext == (w_n - CW'(1))) begin
                    n_pos   = w_total32[coo_pkg::POS_W-1:0];
                    n_state = coo_pkg::S_REPLY;
                end else begin
                    n_idx   = w_idx_p1;
                    n_state = coo_pkg::S_BLD_RD;
                end
            end

            // Clearing pass over all offsets, after reset or on command.
            coo_pkg::S_CLR: begin
                o_ro_we    = 1'b1;
                o_ro_waddr = r_idx;
                o_ro_wdata = '0;
                n_total    = '0;
                if (w_idx_ext == CW'(ROWS_MAX)) begin
                    n_idx       = '0;
                    n_clr_reply = 1'b0;
                    n_state     = r_clr_reply ? coo_pkg::S_REPLY : coo_pkg::S_IDLE;
                end else begin
                    n_idx = w_idx_p1;
                end
            end

            // Hand the result to the output register.
            coo_pkg::S_REPLY: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = coo_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = coo_pkg::S_IDLE;
            end
        endcase
    end

    assign o_pos = r_pos;
    assign o_col = r_col_res;
    assign o_val = r_val_res;
    assign o_sts = r_sts;

endmodule

// ===== src/coo_to_csr_converter.sv =====
// Top level of the COO to CSR converter: config register, memories, sequencer, output register.
//
//  channel   direction  handshake               payload
//  config    in         i_cfg_we                i_cfg_wdata = rows_in_use
//  s (item)  in         i_s_tvalid/o_s_tready   tuser = cmd; tdata = row, col, value
//  m (item)  out        o_m_tvalid/i_m_tready   tdata = position, col_out, value_out;
//                                               tuser = status
//
//  Count, place and read pass through dispatch and read, the update through the shared adder
//  (read only takes the offset) and reply; a rejected row or full count goes straight to reply.
//  Build reads and writes the offsets one active row at a time; clear writes every offset.
//  After reset a clearing pass over all offsets runs; o_s_tready stays low.
//  One item is worked on at a time; o_s_tready returns the cycle after the reply.
//  A held output item stalls the next result, and the input with it.
module coo_to_csr_converter #(
    parameter int ROWS_MAX    = 4096,
    parameter int ENTRIES_MAX = 65536,
    parameter int COL_BITS    = 20,
    localparam int IN_W  = ((coo_pkg::ROW_W + COL_BITS + coo_pkg::VAL_W + 7) / 8) * 8,
    localparam int OUT_W = ((coo_pkg::POS_W + COL_BITS + coo_pkg::VAL_W + 7) / 8) * 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [coo_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    input  logic [IN_W-1:0]           i_s_tdata,   // row, col, value
    input  logic [coo_pkg::CMD_W-1:0] i_s_tuser,   // cmd
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    output logic [OUT_W-1:0]          o_m_tdata,   // position, col_out, value_out
    output logic [coo_pkg::STS_W-1:0] o_m_tuser    // status
);

    localparam int AW  = $clog2(ROWS_MAX + 1);
    localparam int NAW = $clog2(ROWS_MAX);
    localparam int OUT_USED = coo_pkg::POS_W + COL_BITS + coo_pkg::VAL_W;

    // Configuration register.
    logic [coo_pkg::CFG_W-1:0] r_rows_in_use;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_in_use <= coo_pkg::ROWS_RESET;
        end else if (i_cfg_we) begin
            r_rows_in_use <= i_cfg_wdata;
        end
    end

    // Input unpacking.
    logic [coo_pkg::ROW_W-1:0] w_row;
    logic [COL_BITS-1:0]       w_col;
    logic [coo_pkg::VAL_W-1:0] w_val;

    assign w_row = i_s_tdata[coo_pkg::ROW_W-1:0];
    assign w_col = i_s_tdata[coo_pkg::ROW_W +: COL_BITS];
    assign w_val = i_s_tdata[coo_pkg::ROW_W + COL_BITS +: coo_pkg::VAL_W];

    // Wires between the sequencer, the memories and the adder.
    logic                      w_ready;
    logic                      w_res_valid;
    logic                      w_res_ready;
    logic [coo_pkg::POS_W-1:0] w_pos;
    logic [COL_BITS-1:0]       w_col_res;
    logic [coo_pkg::VAL_W-1:0] w_val_res;
    coo_pkg::t_sts             w_sts;
    logic                      w_ro_we;
    logic [AW-1:0]             w_ro_waddr;
    logic [coo_pkg::ACC_W-1:0] w_ro_wdata;
    logic [AW-1:0]             w_ro_raddr;
    logic [coo_pkg::ACC_W-1:0] w_ro_rdata;
    logic                      w_nfs_we;
    logic [NAW-1:0]            w_nfs_waddr;
    logic [coo_pkg::ACC_W-1:0] w_nfs_wdata;
    logic [NAW-1:0]            w_nfs_raddr;
    logic [coo_pkg::ACC_W-1:0] w_nfs_rdata;
    logic [coo_pkg::ACC_W-1:0] w_alu_a;
    logic [coo_pkg::ACC_W-1:0] w_alu_b;
    logic [coo_pkg::ACC_W-1:0] w_alu_sum;
    logic                      w_alu_ge;

    coo_ram #(
        .DEPTH (ROWS_MAX + 1),
        .WIDTH (coo_pkg::ACC_W)
    ) u_row_offsets (
        .i_clk   (i_clk),
        .i_we    (w_ro_we),
        .i_waddr (w_ro_waddr),
        .i_wdata (w_ro_wdata),
        .i_raddr (w_ro_raddr),
        .o_rdata (w_ro_rdata)
    );

    coo_ram #(
        .DEPTH (ROWS_MAX),
        .WIDTH (coo_pkg::ACC_W)
    ) u_next_free (
        .i_clk   (i_clk),
        .i_we    (w_nfs_we),
        .i_waddr (w_nfs_waddr),
        .i_wdata (w_nfs_wdata),
        .i_raddr (w_nfs_raddr),
        .o_rdata (w_nfs_rdata)
    );

    coo_alu #(
        .LIMIT (ENTRIES_MAX)
    ) u_alu (
        .i_a   (w_alu_a),
        .i_b   (w_alu_b),
        .o_sum (w_alu_sum),
        .o_ge  (w_alu_ge)
    );

    coo_ctrl #(
        .ROWS_MAX    (ROWS_MAX),
        .ENTRIES_MAX (ENTRIES_MAX),
        .COL_BITS    (COL_BITS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rows_in_use (r_rows_in_use),
        .i_valid       (i_s_tvalid),
        .o_ready       (w_ready),
        .i_cmd         (coo_pkg::t_cmd'(i_s_tuser)),
        .i_row         (w_row),
        .i_col         (w_col),
        .i_val         (w_val),
        .o_res_valid   (w_res_valid),
        .i_res_ready   (w_res_ready),
        .o_pos         (w_pos),
        .o_col         (w_col_res),
        .o_val         (w_val_res),
        .o_sts         (w_sts),
        .o_ro_we       (w_ro_we),
        .o_ro_waddr    (w_ro_waddr),
        .o_ro_wdata    (w_ro_wdata),
        .o_ro_raddr    (w_ro_raddr),
        .i_ro_rdata    (w_ro_rdata),
        .o_nfs_we      (w_nfs_we),
        .o_nfs_waddr   (w_nfs_waddr),
        .o_nfs_wdata   (w_nfs_wdata),
        .o_nfs_raddr   (w_nfs_raddr),
        .i_nfs_rdata   (w_nfs_rdata),
        .o_alu_a       (w_alu_a),
        .o_alu_b       (w_alu_b),
        .i_alu_sum     (w_alu_sum),
        .i_alu_ge      (w_alu_ge)
    );

    assign o_s_tready = w_ready;

    // Output register; it takes a new result whenever it is empty or being drained.
    logic                      r_m_valid;
    logic [OUT_USED-1:0]       r_m_data;
    logic [coo_pkg::STS_W-1:0] r_m_user;

    assign w_res_ready = !r_m_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_m_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_m_data <= {w_val_res, w_col_res, w_pos};
            r_m_user <= w_sts;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = OUT_W'(r_m_data);
    assign o_m_tuser  = r_m_user;

endmodule

// ===== bench/coo_csr_checker.sv =====
// Checker for the COO to CSR converter: predicts each result item and compares it field by field.
`timescale 1ns / 100ps
module coo_csr_checker #(
    parameter int ROWS_MAX    = 4096,
    parameter int ENTRIES_MAX = 65536,
    parameter int COL_BITS    = 20,
    parameter int IN_W        = 104,
    parameter int OUT_W       = 104
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [coo_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                      i_s_tvalid,
    input  logic                      i_s_tready,
    input  logic [IN_W-1:0]           i_s_tdata,   // row, col, value
    input  logic [coo_pkg::CMD_W-1:0] i_s_tuser,   // cmd
    input  logic                      i_m_tvalid,
    input  logic                      i_m_tready,
    input  logic [OUT_W-1:0]          i_m_tdata,   // position, col_out, value_out
    input  logic [coo_pkg::STS_W-1:0] i_m_tuser,   // status
    output int                        o_fail_count,
    output int                        o_pending
);

    // One result item as the block presents it.
    typedef struct packed {
        logic [coo_pkg::POS_W-1:0] pos;
        logic [COL_BITS-1:0]       col;
        logic [coo_pkg::VAL_W-1:0] val;
        coo_pkg::t_sts             sts;
    } t_csr_item;

    // Shadow copy of the sort state; sums are kept at the full accumulator width.
    logic [coo_pkg::ACC_W-1:0] row_start [0:ROWS_MAX];
    logic [coo_pkg::ACC_W-1:0] free_slot [0:ROWS_MAX-1];
    logic [coo_pkg::ACC_W-1:0] entry_count;
    logic [coo_pkg::CFG_W-1:0] rows_cfg;

    t_csr_item csr_due_q[$];
    t_csr_item got_item;
    t_csr_item want_item;
    int        fails = 0;

    // Works out the result of one item and advances the shadow state.
    function automatic t_csr_item counting_sort_step(input coo_pkg::t_cmd op,
                                                     input logic [coo_pkg::ROW_W-1:0] r,
                                                     input logic [COL_BITS-1:0] c,
                                                     input logic [coo_pkg::VAL_W-1:0] v);
        int unsigned               n;
        logic [coo_pkg::ACC_W-1:0] slot;
        t_csr_item                 res;
        n = (rows_cfg == '0) ? 1 : ((rows_cfg > ROWS_MAX) ? ROWS_MAX : rows_cfg);
        res = '0;
        case (op)
            coo_pkg::CMD_COUNT: begin
                if (r >= n) begin
                    res.sts = coo_pkg::STS_ROW;
                end else if (entry_count >= ENTRIES_MAX) begin
                    res.sts = coo_pkg::STS_FULL;
                end else begin
                    row_start[r + 1] = row_start[r + 1] + 1;
                    entry_count      = entry_count + 1;
                end
                res.pos = entry_count[coo_pkg::POS_W-1:0];
            end
            coo_pkg::CMD_BUILD: begin
                // Exclusive prefix over the active rows; a repeated build sums again.
                for (int i = 0; i < n; i++) begin
                    row_start[i + 1] = row_start[i + 1] + row_start[i];
                    free_slot[i]     = row_start[i];
                end
                res.pos = entry_count[coo_pkg::POS_W-1:0];
            end
            coo_pkg::CMD_PLACE: begin
                if (r >= n) begin
                    res.sts = coo_pkg::STS_ROW;
                end else begin
                    slot = free_slot[r];
                    if (slot >= ENTRIES_MAX) begin
                        res.sts = coo_pkg::STS_FULL;
                    end else begin
                        free_slot[r] = slot + 1;
                        res.pos      = slot[coo_pkg::POS_W-1:0];
                        res.col      = c;
                        res.val      = v;
                    end
                end
            end
            coo_pkg::CMD_READ: begin
                // The offset table has one entry more than there are rows.
                if (r > n)
                    res.sts = coo_pkg::STS_ROW;
                else
                    res.pos = row_start[r][coo_pkg::POS_W-1:0];
            end
            coo_pkg::CMD_CLEAR: begin
                foreach (row_start[i]) row_start[i] = '0;
                entry_count = '0;
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    // Watch all three channels at each rising edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (row_start[i]) row_start[i] = '0;
            foreach (free_slot[i]) free_slot[i] = '0;
            entry_count = '0;
            rows_cfg    = coo_pkg::ROWS_RESET;
            csr_due_q.delete();
        end else begin
            if (i_cfg_we)
                rows_cfg = i_cfg_wdata;

            // A result item is matched against the oldest expectation.
            if (i_m_tvalid && i_m_tready) begin
                got_item.pos = i_m_tdata[coo_pkg::POS_W-1:0];
                got_item.col = i_m_tdata[coo_pkg::POS_W +: COL_BITS];
                got_item.val = i_m_tdata[coo_pkg::POS_W + COL_BITS +: coo_pkg::VAL_W];
                got_item.sts = coo_pkg::t_sts'(i_m_tuser);
                if (csr_due_q.size() == 0) begin
                    if (fails < 10)
                        $display("%0t: result item with nothing expected: pos %0d status %0d",
                                 $realtime, got_item.pos, got_item.sts);
                    fails++;
                end else begin
                    want_item = csr_due_q.pop_front();
                    if (got_item.pos !== want_item.pos || got_item.col !== want_item.col ||
                        got_item.val !== want_item.val || got_item.sts !== want_item.sts) begin
                        if (fails < 10) begin
                            $display("%0t: mismatch, expected pos %0d col %h value %h status %0d",
                                     $realtime, want_item.pos, want_item.col, want_item.val,
                                     want_item.sts);
                            $display("%0t:           actual pos %0d col %h value %h status %0d",
                                     $realtime, got_item.pos, got_item.col, got_item.val,
                                     got_item.sts);
                        end
                        fails++;
                    end
                end
            end

            // Every accepted input item causes exactly one result item.
            if (i_s_tvalid && i_s_tready)
                csr_due_q = {csr_due_q,
                             counting_sort_step(coo_pkg::t_cmd'(i_s_tuser),
                                                i_s_tdata[coo_pkg::ROW_W-1:0],
                                                i_s_tdata[coo_pkg::ROW_W +: COL_BITS],
                                                i_s_tdata[coo_pkg::ROW_W + COL_BITS +:
                                                          coo_pkg::VAL_W])};
        end
        o_fail_count <= fails;
        o_pending    <= csr_due_q.size();
    end

endmodule

// ===== bench/tb_coo_to_csr_converter.sv =====
// Testbench top for the COO to CSR converter: clock, reset, stimulus, idling and the verdict.
`timescale 1ns / 100ps
module tb_coo_to_csr_converter;

    localparam int ROWS_MAX     = 4096;
    localparam int ENTRIES_MAX  = 65536;
    localparam int COL_BITS     = 20;
    localparam int IN_W         = ((coo_pkg::ROW_W + COL_BITS + coo_pkg::VAL_W + 7) / 8) * 8;
    localparam int OUT_W        = ((coo_pkg::POS_W + COL_BITS + coo_pkg::VAL_W + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 400;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      cfg_we    = 1'b0;
    logic [coo_pkg::CFG_W-1:0] cfg_wdata = '0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [IN_W-1:0]           s_tdata   = '0;   // row, col, value
    logic [coo_pkg::CMD_W-1:0] s_tuser   = '0;   // cmd
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [OUT_W-1:0]          m_tdata;          // position, col_out, value_out
    logic [coo_pkg::STS_W-1:0] m_tuser;          // status
    int                        fail_cnt;
    int                        pending_cnt;

    // Stimulus bookkeeping.
    bit                  idle_on      = 1'b1;
    int                  burst_left   = 0;
    int                  rows_now     = coo_pkg::ROWS_RESET;
    int                  rows_built   = 0;
    int                  items_sent   = 0;
    int                  random_first = 0;
    logic [31:0]         ready_bits   = '1;
    int                  ready_step   = 0;

    coo_to_csr_converter #(
        .ROWS_MAX    (ROWS_MAX),
        .ENTRIES_MAX (ENTRIES_MAX),
        .COL_BITS    (COL_BITS)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser)
    );

    coo_csr_checker #(
        .ROWS_MAX    (ROWS_MAX),
        .ENTRIES_MAX (ENTRIES_MAX),
        .COL_BITS    (COL_BITS),
        .IN_W        (IN_W),
        .OUT_W       (OUT_W)
    ) u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_cnt),
        .o_pending    (pending_cnt)
    );

    always #5 clk = ~clk;

    // Receiver: a rotating ready mask, reloaded after each full rotation, sometimes with no stalls.
    always @(posedge clk) begin
        ready_step <= (ready_step == 31) ? 0 : ready_step + 1;
        if (ready_step == 31) begin
            ready_bits <= ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : ($urandom | $urandom);
        end else begin
            ready_bits <= {ready_bits[0], ready_bits[31:1]};
        end
        m_tready <= ready_bits[0] | ~idle_on;
    end

    // Sends one item; while idling is on, bursts of random length are separated by random gaps.
    task automatic push_item(input coo_pkg::t_cmd op, input int row,
                             input logic [COL_BITS-1:0] col,
                             input logic [coo_pkg::VAL_W-1:0] val);
        if (idle_on && burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 16);
        end
        if (burst_left > 0)
            burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= IN_W'({val, col, row[coo_pkg::ROW_W-1:0]});
        do @(posedge clk); while (!s_tready);
        items_sent++;
        if (op == coo_pkg::CMD_BUILD && rows_now > rows_built)
            rows_built = rows_now;
    endtask

    // Command whose row, column and value fields are ignored, sent with random content.
    task automatic push_plain(input coo_pkg::t_cmd op);
        push_item(op, $urandom_range(0, ROWS_MAX), COL_BITS'($urandom), {$urandom, $urandom});
    endtask

    // Stops sending and waits until every expected result item has arrived.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_cnt != 0);
    endtask

    // Writes rows_in_use while the block is idle.
    task automatic set_rows(input int n);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= n[coo_pkg::CFG_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        rows_now  = n;
    endtask

    // Row inside the active range, or now and then past it, up to ROWS_MAX.
    function automatic int pick_row(input int n, input int miss_pct);
        if ($urandom_range(0, 99) < miss_pct)
            return $urandom_range(n, ROWS_MAX);
        return $urandom_range(0, n - 1);
    endfunction

    // Place row: in range only where a build has set the row's next slot.
    function automatic int pick_place_row(input int miss_pct);
        int lim;
        lim = (rows_built < rows_now) ? rows_built : rows_now;
        if (lim == 0 || $urandom_range(0, 99) < miss_pct)
            return $urandom_range(rows_now, ROWS_MAX);
        return $urandom_range(0, lim - 1);
    endfunction

    // Stray item that breaks up the normal count, build, place sequence.
    task automatic push_noise();
        case ($urandom_range(0, 15))
            0:       push_plain(coo_pkg::CMD_CLEAR);
            1, 2:    push_plain(coo_pkg::CMD_BUILD);
            3, 4, 5: push_item(coo_pkg::CMD_READ, $urandom_range(0, ROWS_MAX),
                               COL_BITS'($urandom), {$urandom, $urandom});
            6, 7, 8: push_item(coo_pkg::CMD_PLACE, pick_place_row(50),
                               COL_BITS'($urandom), {$urandom, $urandom});
            default: push_item(coo_pkg::CMD_COUNT, pick_row(rows_now, 50),
                               COL_BITS'($urandom), {$urandom, $urandom});
        endcase
    endtask

    // One matrix: count its entries, build the offsets, replay the entries shuffled, read offsets.
    task automatic run_matrix();
        int                        n;
        int                        k;
        int                        j;
        int                        tmp;
        int                        rows_q[$];
        logic [COL_BITS-1:0]       cols_q[$];
        logic [coo_pkg::VAL_W-1:0] vals_q[$];
        int                        order[$];
        case ($urandom_range(0, 9))
            0:       n = 1;
            1:       n = 2;
            2:       n = ROWS_MAX;
            3:       n = $urandom_range(ROWS_MAX / 2, ROWS_MAX);
            default: n = $urandom_range(3, 48);
        endcase
        set_rows(n);
        if ($urandom_range(0, 2) != 0)
            push_plain(coo_pkg::CMD_CLEAR);

        k = $urandom_range(1, 40);
        for (int i = 0; i < k; i++) begin
            rows_q = {rows_q, pick_row(n, 5)};
            cols_q = {cols_q, COL_BITS'($urandom)};
            vals_q = {vals_q, {$urandom, $urandom}};
            order  = {order, i};
            push_item(coo_pkg::CMD_COUNT, rows_q[i], cols_q[i], vals_q[i]);
            if ($urandom_range(0, 9) == 0)
                push_noise();
        end
        push_plain(coo_pkg::CMD_BUILD);

        // Fisher-Yates shuffle of the replay order.
        for (int i = k - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        foreach (order[i]) begin
            push_item(coo_pkg::CMD_PLACE, rows_q[order[i]], cols_q[order[i]],
                      vals_q[order[i]]);
            if ($urandom_range(0, 7) == 0)
                push_noise();
        end
        repeat ($urandom_range(1, 4))
            push_item(coo_pkg::CMD_READ, $urandom_range(0, (n < ROWS_MAX) ? n + 1 : ROWS_MAX),
                      COL_BITS'($urandom), {$urandom, $urandom});
    endtask

    // Main stimulus and verdict.
    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Four rows: counts with field extremes, rows out of range, two builds, a clear.
        set_rows(4);
        push_item(coo_pkg::CMD_COUNT, 0, '0, '0);
        push_item(coo_pkg::CMD_COUNT, 3, '1, '1);
        push_item(coo_pkg::CMD_COUNT, 3, COL_BITS'($urandom), {$urandom, $urandom});
        push_item(coo_pkg::CMD_COUNT, 4, '1, '1);
        push_item(coo_pkg::CMD_COUNT, ROWS_MAX, '1, '1);
        push_item(coo_pkg::CMD_READ, 5, '0, '0);
        push_plain(coo_pkg::CMD_BUILD);
        push_item(coo_pkg::CMD_READ, 4, '0, '0);
        push_item(coo_pkg::CMD_PLACE, 3, '1, '1);
        push_item(coo_pkg::CMD_PLACE, 0, '0, '0);
        push_item(coo_pkg::CMD_PLACE, 3, COL_BITS'($urandom), {$urandom, $urandom});
        push_item(coo_pkg::CMD_PLACE, 4, '1, '1);
        push_item(coo_pkg::CMD_COUNT, 1, '0, '0);
        push_plain(coo_pkg::CMD_BUILD);
        push_item(coo_pkg::CMD_READ, 2, '0, '0);
        push_item(coo_pkg::CMD_READ, ROWS_MAX, '1, '1);
        push_plain(coo_pkg::CMD_CLEAR);
        push_item(coo_pkg::CMD_PLACE, 3, COL_BITS'($urandom), {$urandom, $urandom});
        push_item(coo_pkg::CMD_READ, 4, '0, '0);

        // A single row.
        set_rows(1);
        push_item(coo_pkg::CMD_COUNT, 0, COL_BITS'($urandom), {$urandom, $urandom});
        push_item(coo_pkg::CMD_COUNT, 1, '0, '0);
        push_plain(coo_pkg::CMD_BUILD);
        push_item(coo_pkg::CMD_PLACE, 0, '1, '0);
        push_item(coo_pkg::CMD_READ, 1, '0, '0);
        push_item(coo_pkg::CMD_READ, 2, '0, '0);

        // Back to back over all rows: repeated builds push the upper slots past capacity.
        idle_on <= 1'b0;
        set_rows(ROWS_MAX);
        push_plain(coo_pkg::CMD_CLEAR);
        push_item(coo_pkg::CMD_COUNT, 0, '1, '1);
        push_item(coo_pkg::CMD_COUNT, ROWS_MAX - 1, '0, '0);
        repeat (3) push_plain(coo_pkg::CMD_BUILD);
        push_item(coo_pkg::CMD_READ, ROWS_MAX, '0, '0);
        push_item(coo_pkg::CMD_READ, ROWS_MAX / 2, '0, '0);
        push_item(coo_pkg::CMD_PLACE, ROWS_MAX - 1, '1, '1);
        push_item(coo_pkg::CMD_PLACE, ROWS_MAX / 2, '1, '1);
        push_item(coo_pkg::CMD_PLACE, 0, COL_BITS'($urandom), {$urandom, $urandom});
        push_item(coo_pkg::CMD_PLACE, 1, COL_BITS'($urandom), {$urandom, $urandom});
        push_plain(coo_pkg::CMD_CLEAR);

        // Random matrices with idling on both sides.
        idle_on <= 1'b1;
        random_first = items_sent;
        while (items_sent - random_first < RANDOM_ITEMS)
            run_matrix();

        drain();
        repeat (100) @(posedge clk);
        if (fail_cnt == 0 && pending_cnt == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Run limit, several times the slowest correct run.
    initial begin
        #40_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
